[sv/sed_pkg.sv]
// ----------------------------------------------------------------------------
// sed_pkg
// Shared constants and types of the Sobel edge detector.
// ----------------------------------------------------------------------------
package sed_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int FW_W    = 11;
	localparam int FH_W    = 13;
	localparam int CFG_W   = 13;
	localparam int IDX_W   = 2;
	localparam int PIX_W   = 32;
	localparam int EDGE_W  = 11;
	localparam int GRAD_W  = 11;
	localparam int EN_W    = 22;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_MODE   = 2'd2;

	localparam logic [FW_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] HEIGHT_RST = 13'd480;

	// conversion modes
	localparam logic MODE_GREY   = 1'b0;
	localparam logic MODE_COLOUR = 1'b1;

	typedef logic [PIX_W-1:0] pixel_t;

endpackage

[sv/sed_pix_if.sv]
// ----------------------------------------------------------------------------
// sed_pix_if
// Pixel request channel: valid/ready with one RGBA raster pixel.
// ----------------------------------------------------------------------------
interface sed_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_red;
	logic [7:0] pixel_green;
	logic [7:0] pixel_blue;
	logic [7:0] pixel_alpha;
	logic       frame_start;

	modport source (output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
		frame_start, input ready);
	modport sink (input valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
		frame_start, output ready);
endinterface

[sv/sed_res_if.sv]
// ----------------------------------------------------------------------------
// sed_res_if
// Result request channel: valid/ready with gradients and magnitudes.
// ----------------------------------------------------------------------------
interface sed_res_if;
	logic               valid;
	logic               ready;
	logic        [10:0] edge_red;
	logic signed [10:0] grad_x_red;
	logic signed [10:0] grad_y_red;
	logic        [10:0] edge_green;
	logic signed [10:0] grad_x_green;
	logic signed [10:0] grad_y_green;
	logic        [10:0] edge_blue;
	logic signed [10:0] grad_x_blue;
	logic signed [10:0] grad_y_blue;
	logic        [7:0]  window_alpha;
	logic               frame_last;

	modport source (output valid, edge_red, grad_x_red, grad_y_red, edge_green,
		grad_x_green, grad_y_green, edge_blue, grad_x_blue, grad_y_blue,
		window_alpha, frame_last, input ready);
	modport sink (input valid, edge_red, grad_x_red, grad_y_red, edge_green,
		grad_x_green, grad_y_green, edge_blue, grad_x_blue, grad_y_blue,
		window_alpha, frame_last, output ready);
endinterface

[sv/sed_isqrt.sv]
// ----------------------------------------------------------------------------
// sed_isqrt
// Iterative floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module sed_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sed_pkg::EN_W-1:0]  value,
	output logic [sed_pkg::EDGE_W-1:0] root,
	output logic                      done
);
	import sed_pkg::*;

	localparam int STEPS = EN_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [EN_W-1:0]  rem_q;
	logic [EN_W-1:0]  res_q;
	logic [EN_W-1:0]  bit_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [EN_W-1:0]  trial;

	assign trial = res_q + bit_q;

	// one digit step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
			bit_q <= EN_W'(1) << (EN_W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[EDGE_W-1:0];
	assign done = done_q;

endmodule

[sv/sobel_edge_detector_top.sv]
// A new pixel is taken only in the idle state: after the line store read-modify-write of the
// last one and, for a pixel that closes a window, after the 11-step square root unit.
// A finished result waits in the output register while the next pixel is taken.
// Reset clears position, window, state, configuration and output valid; the line store is not cleared.
// ----------------------------------------------------------------------------
// sobel_edge_detector_top
// Streaming 3x3 Sobel edge detector with a two-row line store.
// ----------------------------------------------------------------------------
module sobel_edge_detector_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sed_pkg::IDX_W-1:0]  cfg_index,
	input  logic [sed_pkg::CFG_W-1:0]  cfg_data,
	sed_pix_if.sink                    pixel,
	sed_res_if.source                  result
);
	import sed_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_MEM, S_CONV, S_SQ, S_RSTART, S_ROOT, S_DONE
	} state_t;

	typedef logic signed [GRAD_W-1:0] grad_t;

	state_t state_q;

	logic [FW_W-1:0]  width_q;
	logic [FH_W-1:0]  height_q;
	logic             mode_q;
	logic [FW_W-1:0]  w_eff;
	logic [FH_W-1:0]  h_eff;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_cur;
	logic [ROW_W-1:0] row_cur;
	logic             in_range;
	logic             emit;
	logic             last;
	logic             accept;

	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rdata_q;
	logic [COL_W-1:0]   addr_q;
	pixel_t             px_q;
	logic               emit_q;
	logic               last_q;

	pixel_t taps_q [9];
	grad_t  gx_q [3];
	grad_t  gy_q [3];
	logic [EN_W-1:0]   energy_q [3];
	logic [EDGE_W-1:0] root [3];
	logic [2:0]        root_done;
	logic              root_start;

	logic              out_valid_q;
	logic [EDGE_W-1:0] out_edge_q [3];
	grad_t             out_gx_q [3];
	grad_t             out_gy_q [3];
	logic [7:0]        out_alpha_q;
	logic              out_last_q;
	logic              out_free;

	// tap value of one channel, grey average through a reciprocal multiply
	function automatic logic [7:0] tap_val(input pixel_t px, input logic [1:0] ch,
		input logic md);
		logic [9:0]  s;
		logic [18:0] p;
		begin
			s = 10'(px[7:0]) + 10'(px[15:8]) + 10'(px[23:16]);
			p = 19'(s) * 19'(683);
			if (md == MODE_GREY) begin
				tap_val = p[18:11];
			end else begin
				case (ch)
					2'd0:    tap_val = px[7:0];
					2'd1:    tap_val = px[15:8];
					default: tap_val = px[23:16];
				endcase
			end
		end
	endfunction

	// effective frame size
	always_comb begin
		w_eff = width_q;
		if (width_q < FW_W'(3)) w_eff = FW_W'(3);
		if (width_q > FW_W'(MAX_WIDTH)) w_eff = FW_W'(MAX_WIDTH);
		h_eff = height_q;
		if (height_q < FH_W'(3)) h_eff = FH_W'(3);
		if (height_q > FH_W'(MAX_HEIGHT)) h_eff = FH_W'(MAX_HEIGHT);
	end

	// position of the incoming pixel
	always_comb begin
		col_cur  = pixel.frame_start ? '0 : col_q;
		row_cur  = pixel.frame_start ? '0 : row_q;
		in_range = (FW_W'(col_cur) < w_eff) && (FH_W'(row_cur) < h_eff);
		emit     = in_range && (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2));
		last     = (FW_W'(col_cur) == w_eff - 1'b1) && (FH_W'(row_cur) == h_eff - 1'b1);
	end

	assign pixel.ready = (state_q == S_IDLE);
	assign accept      = pixel.valid && pixel.ready;
	assign out_free    = !out_valid_q || result.ready;
	assign root_start  = (state_q == S_RSTART);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			mode_q   <= MODE_GREY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[FW_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[FH_W-1:0];
				REG_MODE:   mode_q   <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// line store, one entry holds the top and middle row pixels of a column
	always_ff @(posedge clk) begin
		if (accept && in_range) begin
			rdata_q <= line_mem[col_cur];
		end
		if (state_q == S_MEM) begin
			line_mem[addr_q] <= {px_q, rdata_q[2*PIX_W-1:PIX_W]};
		end
	end

	// sequencer, position counters and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			addr_q  <= '0;
			px_q    <= '0;
			emit_q  <= 1'b0;
			last_q  <= 1'b0;
			for (int i = 0; i < 9; i++) taps_q[i] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q <= col_cur;
						px_q   <= {pixel.pixel_alpha, pixel.pixel_blue,
							pixel.pixel_green, pixel.pixel_red};
						emit_q <= emit;
						last_q <= last;
						if (FW_W'(col_cur) + 1'b1 >= w_eff) begin
							col_q <= '0;
							row_q <= (FH_W'(row_cur) + 1'b1 >= h_eff) ? '0 : row_cur + 1'b1;
						end else begin
							col_q <= col_cur + 1'b1;
							row_q <= row_cur;
						end
						if (in_range) state_q <= S_MEM;
					end
				end
				S_MEM: begin
					for (int r = 0; r < 3; r++) begin
						taps_q[r*3]   <= taps_q[r*3+1];
						taps_q[r*3+1] <= taps_q[r*3+2];
					end
					taps_q[2] <= rdata_q[PIX_W-1:0];
					taps_q[5] <= rdata_q[2*PIX_W-1:PIX_W];
					taps_q[8] <= px_q;
					state_q   <= emit_q ? S_CONV : S_IDLE;
				end
				S_CONV:   state_q <= S_SQ;
				S_SQ:     state_q <= S_RSTART;
				S_RSTART: state_q <= S_ROOT;
				S_ROOT:   if (&root_done) state_q <= S_DONE;
				S_DONE:   if (out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// gradients and energy per channel
	always_ff @(posedge clk) begin
		logic [7:0]  t [9];
		logic [11:0] xp, xn, yp, yn;
		logic [11:0] dx, dy;
		logic signed [EN_W-1:0] sx, sy;
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 9; i++) t[i] = tap_val(taps_q[i], 2'(ch), mode_q);
			xp = 12'(t[2]) + (12'(t[5]) << 1) + 12'(t[8]);
			xn = 12'(t[0]) + (12'(t[3]) << 1) + 12'(t[6]);
			yp = 12'(t[6]) + (12'(t[7]) << 1) + 12'(t[8]);
			yn = 12'(t[0]) + (12'(t[1]) << 1) + 12'(t[2]);
			dx = xp - xn;
			dy = yp - yn;
			sx = gx_q[ch];
			sy = gy_q[ch];
			if (state_q == S_CONV) begin
				gx_q[ch] <= grad_t'(dx[GRAD_W-1:0]);
				gy_q[ch] <= grad_t'(dy[GRAD_W-1:0]);
			end
			if (state_q == S_SQ) begin
				energy_q[ch] <= $unsigned(sx * sx) + $unsigned(sy * sy);
			end
		end
	end

	// square root units, one per channel
	for (genvar g = 0; g < 3; g++) begin : g_root
		sed_isqrt u_isqrt (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (root_start),
			.value  (energy_q[g]),
			.root   (root[g]),
			.done   (root_done[g])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			for (int ch = 0; ch < 3; ch++) begin
				out_edge_q[ch] <= root[ch];
				out_gx_q[ch]   <= gx_q[ch];
				out_gy_q[ch]   <= gy_q[ch];
			end
			out_alpha_q <= taps_q[0][31:24];
			out_last_q  <= last_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.edge_red     = out_edge_q[0];
	assign result.grad_x_red   = out_gx_q[0];
	assign result.grad_y_red   = out_gy_q[0];
	assign result.edge_green   = out_edge_q[1];
	assign result.grad_x_green = out_gx_q[1];
	assign result.grad_y_green = out_gy_q[1];
	assign result.edge_blue    = out_edge_q[2];
	assign result.grad_x_blue  = out_gx_q[2];
	assign result.grad_y_blue  = out_gy_q[2];
	assign result.window_alpha = out_alpha_q;
	assign result.frame_last   = out_last_q;

endmodule

[sv/sed_checker.sv]
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks of the Sobel edge detector, bound to the top level.
// ----------------------------------------------------------------------------
module sed_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_alpha
);
	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// a stalled result stays valid and keeps its alpha
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_alpha))
		else $error("result dropped or changed while stalled");

	// the block only goes busy after taking a pixel
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_acc))
		else $error("pixel input stalled without a pixel request");

	// a result cannot appear right after a pixel request
	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_acc))
		else $error("result shown too early");
endmodule

bind sobel_edge_detector_top sed_checker u_sed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_alpha (result.window_alpha)
);
